### rtl/core/ctou_pkg.sv
`timescale 1ns / 1ps
package ctou_pkg;

  localparam int CoordBits = 16;
  localparam int DirBits   = 16;
  localparam int DirFrac   = 14;

  localparam int DcW   = CoordBits + 3;
  localparam int ProdW = DirBits + CoordBits;
  localparam int VecW  = ((DcW + DirFrac) > (ProdW + 1) ? (DcW + DirFrac) : (ProdW + 1)) + 1;
  localparam int MulW  = 2 * VecW;
  localparam int DotW  = MulW + 2;
  localparam int MagW  = MulW;
  localparam int HalfW = MagW / 2;
  localparam int WideW = 2 * MagW;
  localparam int RadW  = 2 * (CoordBits - 1);

  localparam int Depth = 8;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
  } ctou_vec_t;

  typedef struct packed {
    logic vtx;
    logic in_tri;
    logic near;
  } ctou_edge_res_t;

endpackage

### rtl/core/circle_triangle_overlap_unit.sv
`timescale 1ns / 1ps
// Throughput: one query per cycle; the pipeline holds while a result
// waits under out_stall_i.
// Reset: asynchronous, active low; clears all valid bits, so no result
// is pending after reset.
module circle_triangle_overlap_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [ctou_pkg::CoordBits-1:0] circle_x_i,
  input  logic signed [ctou_pkg::CoordBits-1:0] circle_y_i,
  input  logic        [ctou_pkg::CoordBits-2:0] circle_w_i,
  input  logic        [ctou_pkg::CoordBits-2:0] circle_h_i,
  input  logic signed [ctou_pkg::CoordBits-1:0] tri_x_i,
  input  logic signed [ctou_pkg::CoordBits-1:0] tri_y_i,
  input  logic        [ctou_pkg::CoordBits-2:0] tri_w_i,
  input  logic        [ctou_pkg::CoordBits-2:0] tri_h_i,
  input  logic signed [ctou_pkg::DirBits-1:0]   tri_dir_x_i,
  input  logic signed [ctou_pkg::DirBits-1:0]   tri_dir_y_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 hit_o
);

  logic                      adv;
  logic [ctou_pkg::Depth-1:0] vld_q, vld_d;
  logic                      hit_d, hit_q;
  logic [ctou_pkg::CoordBits-2:0] ch;
  ctou_pkg::ctou_vec_t       c [3];
  ctou_pkg::ctou_vec_t       e [3];
  ctou_pkg::ctou_edge_res_t  res [3];

  assign adv        = !(vld_q[ctou_pkg::Depth-1] && out_stall_i);
  assign in_stall_o = !adv;
  assign vld_d      = {vld_q[ctou_pkg::Depth-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  ctou_front u_front (
    .clk_i,
    .en_i       (adv),
    .circle_x_i,
    .circle_y_i,
    .circle_w_i,
    .circle_h_i,
    .tri_x_i,
    .tri_y_i,
    .tri_w_i,
    .tri_h_i,
    .tri_dir_x_i,
    .tri_dir_y_i,
    .c_o        (c),
    .e_o        (e),
    .ch_o       (ch)
  );

  for (genvar i = 0; i < 3; i++) begin : g_edge
    ctou_edge u_edge (
      .clk_i,
      .en_i  (adv),
      .c_i   (c[i]),
      .e_i   (e[i]),
      .ch_i  (ch),
      .res_o (res[i])
    );
  end

  assign hit_d = res[0].vtx || res[1].vtx || res[2].vtx
              || (res[0].in_tri && res[1].in_tri && res[2].in_tri)
              || res[0].near || res[1].near || res[2].near;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= hit_d;
    end
  end

  assign out_valid_o = vld_q[ctou_pkg::Depth-1];
  assign hit_o       = hit_q;

endmodule

### rtl/core/ctou_front.sv
`timescale 1ns / 1ps
module ctou_front (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [ctou_pkg::CoordBits-1:0] circle_x_i,
  input  logic signed [ctou_pkg::CoordBits-1:0] circle_y_i,
  input  logic        [ctou_pkg::CoordBits-2:0] circle_w_i,
  input  logic        [ctou_pkg::CoordBits-2:0] circle_h_i,
  input  logic signed [ctou_pkg::CoordBits-1:0] tri_x_i,
  input  logic signed [ctou_pkg::CoordBits-1:0] tri_y_i,
  input  logic        [ctou_pkg::CoordBits-2:0] tri_w_i,
  input  logic        [ctou_pkg::CoordBits-2:0] tri_h_i,
  input  logic signed [ctou_pkg::DirBits-1:0]   tri_dir_x_i,
  input  logic signed [ctou_pkg::DirBits-1:0]   tri_dir_y_i,
  output ctou_pkg::ctou_vec_t                   c_o [3],
  output ctou_pkg::ctou_vec_t                   e_o [3],
  output logic        [ctou_pkg::CoordBits-2:0] ch_o
);

  logic signed [ctou_pkg::DcW-1:0]   dcx_d, dcy_d, dcx_q, dcy_q;
  logic signed [ctou_pkg::ProdW-1:0] pa_d, pb_d, pc_d, pd_d, pa_q, pb_q, pc_q, pd_q;
  logic        [ctou_pkg::CoordBits-2:0] ch1_q, ch2_q;
  logic signed [ctou_pkg::VecW-1:0]  a, b, c, d, cx, cy;
  ctou_pkg::ctou_vec_t c_d [3], e_d [3], c_q [3], e_q [3];

  always_comb begin
    dcx_d = (ctou_pkg::DcW'(circle_x_i) <<< 1) + ctou_pkg::DcW'({1'b0, circle_w_i})
          - (ctou_pkg::DcW'(tri_x_i) <<< 1) - ctou_pkg::DcW'({1'b0, tri_w_i});
    dcy_d = (ctou_pkg::DcW'(circle_y_i) <<< 1) + ctou_pkg::DcW'({1'b0, circle_h_i})
          - (ctou_pkg::DcW'(tri_y_i) <<< 1) - ctou_pkg::DcW'({1'b0, tri_h_i});
    pa_d  = tri_dir_y_i * $signed({1'b0, tri_w_i});
    pb_d  = tri_dir_x_i * $signed({1'b0, tri_h_i});
    pc_d  = tri_dir_x_i * $signed({1'b0, tri_w_i});
    pd_d  = tri_dir_y_i * $signed({1'b0, tri_h_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dcx_q <= dcx_d;
      dcy_q <= dcy_d;
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      pc_q  <= pc_d;
      pd_q  <= pd_d;
      ch1_q <= circle_h_i;
    end
  end

  always_comb begin
    a  = ctou_pkg::VecW'(pa_q);
    b  = ctou_pkg::VecW'(pb_q);
    c  = ctou_pkg::VecW'(pc_q);
    d  = ctou_pkg::VecW'(pd_q);
    cx = ctou_pkg::VecW'(dcx_q) <<< ctou_pkg::DirFrac;
    cy = ctou_pkg::VecW'(dcy_q) <<< ctou_pkg::DirFrac;
    c_d[0].x = cx;
    c_d[0].y = cy;
    e_d[0].x = a + b;
    e_d[0].y = d - c;
    c_d[1].x = cx - (a + b);
    c_d[1].y = cy - (d - c);
    e_d[1].x = -(a <<< 1);
    e_d[1].y = c <<< 1;
    c_d[2].x = cx - (b - a);
    c_d[2].y = cy - (c + d);
    e_d[2].x = a - b;
    e_d[2].y = -(c + d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q   <= c_d;
      e_q   <= e_d;
      ch2_q <= ch1_q;
    end
  end

  assign c_o  = c_q;
  assign e_o  = e_q;
  assign ch_o = ch2_q;

endmodule

### rtl/core/ctou_edge.sv
`timescale 1ns / 1ps
module ctou_edge (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  ctou_pkg::ctou_vec_t                   c_i,
  input  ctou_pkg::ctou_vec_t                   e_i,
  input  logic        [ctou_pkg::CoordBits-2:0] ch_i,
  output ctou_pkg::ctou_edge_res_t              res_o
);

  logic signed [ctou_pkg::MulW-1:0] pxx_q, pyy_q, pca_q, pcb_q, pka_q, pkb_q, plx_q, ply_q;
  logic        [ctou_pkg::RadW-1:0] rad_q;
  logic signed [ctou_pkg::DotW-1:0] q_d, cr_d, k_d, len_d, q_q, cr_q, k_q, len_q;
  logic        [ctou_pkg::MulW-1:0] kk_hh_q, kk_hl_q, kk_ll_q, ql_hh_q, ql_hl_q, ql_lh_q, ql_ll_q;
  logic        [ctou_pkg::WideW-1:0] kk_d, ql_d, kk_q, ql_q;
  logic        [ctou_pkg::HalfW-1:0] kh, kl, qh, ql, lh, ll;
  logic        vtx5_q, ins5_q, gate5_q, vtx6_q, ins6_q, gate6_q;
  ctou_pkg::ctou_edge_res_t res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pxx_q <= c_i.x * c_i.x;
      pyy_q <= c_i.y * c_i.y;
      pca_q <= e_i.y * c_i.x;
      pcb_q <= e_i.x * c_i.y;
      pka_q <= c_i.x * e_i.x;
      pkb_q <= c_i.y * e_i.y;
      plx_q <= e_i.x * e_i.x;
      ply_q <= e_i.y * e_i.y;
      rad_q <= ch_i * ch_i;
    end
  end

  always_comb begin
    q_d   = ctou_pkg::DotW'(pxx_q) + ctou_pkg::DotW'(pyy_q)
          - (ctou_pkg::DotW'({1'b0, rad_q}) <<< (2 * ctou_pkg::DirFrac));
    cr_d  = ctou_pkg::DotW'(pca_q) - ctou_pkg::DotW'(pcb_q);
    k_d   = ctou_pkg::DotW'(pka_q) + ctou_pkg::DotW'(pkb_q);
    len_d = ctou_pkg::DotW'(plx_q) + ctou_pkg::DotW'(ply_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q   <= q_d;
      cr_q  <= cr_d;
      k_q   <= k_d;
      len_q <= len_d;
    end
  end

  assign kh = k_q[ctou_pkg::MagW-1:ctou_pkg::HalfW];
  assign kl = k_q[ctou_pkg::HalfW-1:0];
  assign qh = q_q[ctou_pkg::MagW-1:ctou_pkg::HalfW];
  assign ql = q_q[ctou_pkg::HalfW-1:0];
  assign lh = len_q[ctou_pkg::MagW-1:ctou_pkg::HalfW];
  assign ll = len_q[ctou_pkg::HalfW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kk_hh_q <= kh * kh;
      kk_hl_q <= kh * kl;
      kk_ll_q <= kl * kl;
      ql_hh_q <= qh * lh;
      ql_hl_q <= qh * ll;
      ql_lh_q <= ql * lh;
      ql_ll_q <= ql * ll;
      vtx5_q  <= !(q_q > 0);
      ins5_q  <= cr_q < 0;
      gate5_q <= (k_q > 0) && (k_q < len_q);
    end
  end

  always_comb begin
    kk_d = (ctou_pkg::WideW'(kk_hh_q) << ctou_pkg::MagW)
         + (ctou_pkg::WideW'(kk_hl_q) << (ctou_pkg::HalfW + 1))
         + ctou_pkg::WideW'(kk_ll_q);
    ql_d = (ctou_pkg::WideW'(ql_hh_q) << ctou_pkg::MagW)
         + ((ctou_pkg::WideW'(ql_hl_q) + ctou_pkg::WideW'(ql_lh_q)) << ctou_pkg::HalfW)
         + ctou_pkg::WideW'(ql_ll_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kk_q    <= kk_d;
      ql_q    <= ql_d;
      vtx6_q  <= vtx5_q;
      ins6_q  <= ins5_q;
      gate6_q <= gate5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.vtx    <= vtx6_q;
      res_q.in_tri <= ins6_q;
      res_q.near   <= gate6_q && !(kk_q < ql_q);
    end
  end

  assign res_o = res_q;

endmodule

### rtl/core/ctou_checker.sv
`timescale 1ns / 1ps
module ctou_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic signed [ctou_pkg::CoordBits-1:0] circle_x_i,
  input logic signed [ctou_pkg::CoordBits-1:0] circle_y_i,
  input logic        [ctou_pkg::CoordBits-2:0] circle_w_i,
  input logic        [ctou_pkg::CoordBits-2:0] circle_h_i,
  input logic signed [ctou_pkg::CoordBits-1:0] tri_x_i,
  input logic signed [ctou_pkg::CoordBits-1:0] tri_y_i,
  input logic        [ctou_pkg::CoordBits-2:0] tri_w_i,
  input logic        [ctou_pkg::CoordBits-2:0] tri_h_i,
  input logic signed [ctou_pkg::DirBits-1:0]   tri_dir_x_i,
  input logic signed [ctou_pkg::DirBits-1:0]   tri_dir_y_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic                                 hit_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable({circle_x_i, circle_y_i, circle_w_i,
      circle_h_i, tri_x_i, tri_y_i, tri_w_i, tri_h_i, tri_dir_x_i, tri_dir_y_i}))
    else $error("stalled input transfer changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");

  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output empty");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> out_valid_o)
    else $error("stall released a result without transfer");

endmodule

bind circle_triangle_overlap_unit ctou_checker u_ctou_checker (.*);

### bench/circle_triangle_overlap_unit_test.sv
`timescale 1ns / 1ps
module circle_triangle_overlap_unit_test;

  localparam int CB = ctou_pkg::CoordBits;
  localparam int DB = ctou_pkg::DirBits;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    logic signed [CB-1:0]      cx;
    logic signed [CB-1:0]      cy;
    logic        [CB-2:0]      cw;
    logic        [CB-2:0]      ch;
    logic signed [CB-1:0]      tx;
    logic signed [CB-1:0]      ty;
    logic        [CB-2:0]      tw;
    logic        [CB-2:0]      th;
    logic signed [DB-1:0]      dx;
    logic signed [DB-1:0]      dy;
  } query_t;

  typedef logic signed [191:0] wide_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CB-1:0] circle_x_i = '0, circle_y_i = '0, tri_x_i = '0, tri_y_i = '0;
  logic [CB-2:0] circle_w_i = '0, circle_h_i = '0, tri_w_i = '0, tri_h_i = '0;
  logic signed [DB-1:0] tri_dir_x_i = '0, tri_dir_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;

  query_t pending_queries[$];
  logic   expected_hits[$];
  int     mismatch_count = 0;
  int     send_idle_pct = 0;
  int     stall_pct = 0;
  int     hold_off_cycles = 0;
  int     quiet_cycles = 0;
  bit     stimulus_done = 1'b0;

  circle_triangle_overlap_unit dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic wide_t dot2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
    return ax * bx + ay * by;
  endfunction

  function automatic bit edge_near(wide_t cx, wide_t cy, wide_t ex, wide_t ey, wide_t dist2);
    wide_t k;
    wide_t len;
    k = dot2(cx, cy, ex, ey);
    if (k <= 0) return 1'b0;
    len = dot2(ex, ey, ex, ey);
    if (k >= len) return 1'b0;
    return !(k * k < dist2 * len);
  endfunction

  function automatic logic overlap_hit(query_t q);
    wide_t cx, cy, dx, dy, tw, th, r2;
    wide_t p1x, p1y, p2x, p2y, c1x, c1y, c2x, c2y, q0, q1, q2;
    dx = q.dx;
    dy = q.dy;
    tw = {1'b0, q.tw};
    th = {1'b0, q.th};
    cx = (2 * wide_t'(q.cx) + wide_t'({1'b0, q.cw}) - 2 * wide_t'(q.tx) - tw) * 16384;
    cy = (2 * wide_t'(q.cy) + wide_t'({1'b0, q.ch}) - 2 * wide_t'(q.ty) - th) * 16384;
    r2 = wide_t'({1'b0, q.ch}) * 16384;
    r2 = r2 * r2;
    p1x = dy * tw + dx * th;
    p1y = -dx * tw + dy * th;
    p2x = -dy * tw + dx * th;
    p2y = dx * tw + dy * th;
    c1x = cx - p1x;
    c1y = cy - p1y;
    c2x = cx - p2x;
    c2y = cy - p2y;
    q0 = dot2(cx, cy, cx, cy) - r2;
    q1 = dot2(c1x, c1y, c1x, c1y) - r2;
    q2 = dot2(c2x, c2y, c2x, c2y) - r2;
    if (q0 <= 0 || q1 <= 0 || q2 <= 0) return 1'b1;
    if (dot2(p1y, -p1x, cx, cy) < 0 && dot2(p2y - p1y, p1x - p2x, c1x, c1y) < 0 &&
        dot2(-p2y, p2x, c2x, c2y) < 0) return 1'b1;
    return edge_near(cx, cy, p1x, p1y, q0) || edge_near(c1x, c1y, p2x - p1x, p2y - p1y, q1) ||
           edge_near(c2x, c2y, -p2x, -p2y, q2);
  endfunction

  function automatic logic signed [DB-1:0] pick_dir();
    case ($urandom_range(0, 5))
      0: return DB'($urandom);
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'sd0;
      default: return DB'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int span;
    int base_x;
    int base_y;
    span = $urandom_range(0, 3) == 0 ? 32767 : (1 << $urandom_range(2, 11));
    base_x = $signed($urandom_range(0, 65535)) - 32768;
    base_y = $signed($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 4) == 0) begin
      q.cx = CB'($urandom);
      q.cy = CB'($urandom);
      q.tx = CB'($urandom);
      q.ty = CB'($urandom);
      q.cw = (CB-1)'($urandom);
      q.ch = (CB-1)'($urandom);
      q.tw = (CB-1)'($urandom);
      q.th = (CB-1)'($urandom);
    end else begin
      q.cx = CB'(base_x + $signed($urandom_range(0, 2 * span)) - span);
      q.cy = CB'(base_y + $signed($urandom_range(0, 2 * span)) - span);
      q.tx = CB'(base_x);
      q.ty = CB'(base_y);
      q.cw = (CB-1)'($urandom_range(0, span));
      q.ch = (CB-1)'($urandom_range(0, span));
      q.tw = (CB-1)'($urandom_range(0, span));
      q.th = (CB-1)'($urandom_range(0, span));
    end
    q.dx = pick_dir();
    q.dy = pick_dir();
    return q;
  endfunction

  function automatic query_t make_query(int cx, int cy, int cw, int ch, int tx, int ty,
                                        int tw, int th, int dx, int dy);
    query_t q;
    q.cx = CB'(cx);
    q.cy = CB'(cy);
    q.cw = (CB-1)'(cw);
    q.ch = (CB-1)'(ch);
    q.tx = CB'(tx);
    q.ty = CB'(ty);
    q.tw = (CB-1)'(tw);
    q.th = (CB-1)'(th);
    q.dx = DB'(dx);
    q.dy = DB'(dy);
    return q;
  endfunction

  task automatic run_phase(int items, int idle_pct, int stall_p);
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    repeat (items) pending_queries.push_back(random_query());
    wait (pending_queries.size() == 0 && expected_hits.size() == 0 && !in_valid_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(-32768, -32768, 32767, 32767, 32767, 32767,
                                         32767, 32767, -32768, -32768));
    pending_queries.push_back(make_query(32767, 32767, 32767, 32767, -32768, -32768,
                                         32767, 32767, 32767, 32767));
    pending_queries.push_back(make_query(0, 0, 32, 32, 0, 0, 32, 32, 0, 16384));
    pending_queries.push_back(make_query(100, 100, 10, 10, 0, 0, 64, 64, 16384, 0));
    pending_queries.push_back(make_query(100, 100, 10, 10, 0, 0, 0, 0, 0, 16384));
    pending_queries.push_back(make_query(32, 32, 0, 0, 0, 0, 64, 64, 0, 16384));
    pending_queries.push_back(make_query(32, 60, 0, 0, 0, 0, 64, 64, 0, 16384));
    pending_queries.push_back(make_query(30, 80, 4, 0, 0, 0, 64, 64, 0, 16384));
    pending_queries.push_back(make_query(30, 40, 4, 4, 0, 0, 64, 64, 0, 16384));
    pending_queries.push_back(make_query(0, 0, 64, 64, 0, 0, 64, 64, 11585, 11585));
    pending_queries.push_back(make_query(200, 0, 8, 20, 0, 0, 64, 64, -16384, 0));
    pending_queries.push_back(make_query(10, 10, 4, 4, 0, 0, 64, 64, -32768, 32767));
    pending_queries.push_back(make_query(0, 0, 1, 1, 0, 0, 32767, 32767, 16384, 16384));
    pending_queries.push_back(make_query(32767, -32768, 0, 32767, -32768, 32767, 0, 0,
                                         0, 0));
    wait (pending_queries.size() == 0 && expected_hits.size() == 0 && !in_valid_i);
    run_phase(210, 0, 0);
    run_phase(210, 46, 0);
    hold_off_cycles = 60;
    run_phase(210, 0, 46);
    run_phase(210, 37, 37);
    stimulus_done = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) expected_hits.push_back(overlap_hit(make_query(circle_x_i, circle_y_i,
        circle_w_i, circle_h_i, tri_x_i, tri_y_i, tri_w_i, tri_h_i, tri_dir_x_i, tri_dir_y_i)));
      if (pending_queries.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        query_t q;
        q = pending_queries.pop_front();
        in_valid_i <= 1'b1;
        circle_x_i <= q.cx;
        circle_y_i <= q.cy;
        circle_w_i <= q.cw;
        circle_h_i <= q.ch;
        tri_x_i <= q.tx;
        tri_y_i <= q.ty;
        tri_w_i <= q.tw;
        tri_h_i <= q.th;
        tri_dir_x_i <= q.dx;
        tri_dir_y_i <= q.dy;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rst_ni && ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hits.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) $display("unexpected transfer: hit=%0b", hit_o);
      end else begin
        logic exp_hit;
        exp_hit = expected_hits.pop_front();
        if (hit_o !== exp_hit) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("hit mismatch: expected %0b, got %0b", exp_hit, hit_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ctou_pkg.sv
rtl/core/ctou_front.sv
rtl/core/ctou_edge.sv
rtl/core/circle_triangle_overlap_unit.sv
rtl/core/ctou_checker.sv
bench/circle_triangle_overlap_unit_test.sv
